[rtl/qdd_pkg.sv]
`timescale 1ns / 1ps

package qdd_pkg;

    // widths fixed by the item and register fields
    localparam int PENDING_W = 8;
    localparam int STEPS_W   = 3;
    localparam int MASK_W    = 4;
    localparam int ACCUM_W   = 4;
    localparam int CFG_W     = 4;

    // default saturation bound of the pending detent count
    localparam int PENDING_LIMIT_DEF = 64;

    // register reset values
    localparam logic [STEPS_W-1:0] DETENT_STEPS_RST = 3'd4;
    localparam logic [MASK_W-1:0]  DETENT_MASK_RST  = 4'b0001;

    // accumulator saturation bounds
    localparam logic signed [ACCUM_W:0] ACCUM_MAX = 5'sd7;
    localparam logic signed [ACCUM_W:0] ACCUM_MIN = -5'sd8;

    typedef enum logic [0:0] {
        CFG_DETENT_STEPS = 1'b0,
        CFG_DETENT_MASK  = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        KIND_SAMPLE  = 1'b0,
        KIND_CONSUME = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef struct packed {
        logic [STEPS_W-1:0] detent_steps;
        logic [MASK_W-1:0]  detent_state_mask;
    } qdd_cfg_t;

    typedef struct packed {
        dir_t                        direction;
        logic signed [PENDING_W-1:0] pending_count;
    } qdd_result_t;

    // quadrature transition table: previous state, current state -> -1, 0, +1
    function automatic logic signed [1:0] quad_step(input logic [1:0] prev,
                                                    input logic [1:0] cur);
        logic signed [1:0] d;
        unique case ({prev, cur})
            4'b00_01: d = -2'sd1;
            4'b00_10: d =  2'sd1;
            4'b01_00: d =  2'sd1;
            4'b01_11: d = -2'sd1;
            4'b10_00: d = -2'sd1;
            4'b10_11: d =  2'sd1;
            4'b11_01: d =  2'sd1;
            4'b11_10: d = -2'sd1;
            default:  d =  2'sd0;
        endcase
        return d;
    endfunction

endpackage

[rtl/qdd_cfg_regs.sv]
`timescale 1ns / 1ps

module qdd_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [0:0]                  cfg_index,
    input  logic [qdd_pkg::CFG_W-1:0]   cfg_data,
    output qdd_pkg::qdd_cfg_t           cfg
);
    import qdd_pkg::*;

    logic [STEPS_W-1:0] steps_reg;
    logic [MASK_W-1:0]  mask_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= DETENT_STEPS_RST;
            mask_reg  <= DETENT_MASK_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DETENT_STEPS: steps_reg <= cfg_data[STEPS_W-1:0];
                CFG_DETENT_MASK:  mask_reg  <= cfg_data[MASK_W-1:0];
            endcase
        end
    end

    assign cfg.detent_steps      = steps_reg;
    assign cfg.detent_state_mask = mask_reg;

endmodule

[rtl/qdd_core.sv]
`timescale 1ns / 1ps

module qdd_core #(
    parameter int PENDING_LIMIT = qdd_pkg::PENDING_LIMIT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qdd_pkg::qdd_cfg_t     cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_kind,
    input  logic [1:0]            in_pins,
    output logic                  out_valid,
    input  logic                  out_ready,
    output qdd_pkg::qdd_result_t  out_result
);
    import qdd_pkg::*;

    localparam logic signed [PENDING_W-1:0] LIMIT_POS = PENDING_W'(PENDING_LIMIT);
    localparam logic signed [PENDING_W-1:0] LIMIT_NEG = -LIMIT_POS;

    // input stage
    logic       in_valid_reg, in_valid_next;
    kind_t      in_kind_reg;
    logic [1:0] in_pins_reg;

    // decoder state
    logic [1:0]                  last_pins_reg, last_pins_next;
    logic signed [ACCUM_W-1:0]   accum_reg, accum_next;
    logic signed [PENDING_W-1:0] pending_reg, pending_next;

    // result stage
    logic        out_valid_reg, out_valid_next;
    qdd_result_t result_reg, result_next;

    logic                      advance;
    logic signed [1:0]         d;
    logic signed [ACCUM_W:0]   acc_sum;
    logic signed [ACCUM_W:0]   acc_sat;
    logic signed [ACCUM_W:0]   steps_s;
    logic                      hit_up;
    logic                      hit_down;
    dir_t                      dir;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // step lookup and saturating accumulate
    assign d       = quad_step(last_pins_reg, in_pins_reg);
    assign acc_sum = {accum_reg[ACCUM_W-1], accum_reg} + {{(ACCUM_W-1){d[1]}}, d};
    assign acc_sat = (acc_sum > ACCUM_MAX) ? ACCUM_MAX :
                     (acc_sum < ACCUM_MIN) ? ACCUM_MIN : acc_sum;
    assign steps_s  = signed'({2'b00, cfg.detent_steps});
    assign hit_up   = acc_sat >= steps_s;
    assign hit_down = acc_sat <= -steps_s;

    // next state and result for the item in the input stage
    always_comb
    begin
        last_pins_next = last_pins_reg;
        accum_next     = accum_reg;
        pending_next   = pending_reg;
        dir            = DIR_NONE;
        if (advance)
        begin
            if (in_kind_reg == KIND_SAMPLE)
            begin
                last_pins_next = in_pins_reg;
                if (d != 2'sd0)
                begin
                    accum_next = acc_sat[ACCUM_W-1:0];
                    if (cfg.detent_state_mask[in_pins_reg])
                    begin
                        accum_next = '0;
                        if (hit_up)
                        begin
                            if (pending_reg < LIMIT_POS)
                                pending_next = pending_reg + 8'sd1;
                        end
                        else if (hit_down)
                        begin
                            if (pending_reg > LIMIT_NEG)
                                pending_next = pending_reg - 8'sd1;
                        end
                    end
                end
            end
            else
            begin
                // consume moves the count one step toward zero
                if (pending_reg > 8'sd0)
                begin
                    pending_next = pending_reg - 8'sd1;
                    dir          = DIR_UP;
                end
                else if (pending_reg < 8'sd0)
                begin
                    pending_next = pending_reg + 8'sd1;
                    dir          = DIR_DOWN;
                end
            end
        end
    end

    // handshake bookkeeping for both stages
    always_comb
    begin
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        result_next               = result_reg;
        if (advance)
        begin
            result_next.direction     = dir;
            result_next.pending_count = pending_next;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_pins_reg <= '0;
            accum_reg     <= '0;
            pending_reg   <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            last_pins_reg <= last_pins_next;
            accum_reg     <= accum_next;
            pending_reg   <= pending_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_kind_reg <= kind_t'(in_kind);
            in_pins_reg <= in_pins;
        end
        result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

[rtl/quadrature_detent_decoder_unit.sv]
`timescale 1ns / 1ps

// Rotary quadrature decoder with detent counting. Each input beat is either a
// pin sample (tuser 0) or a request to consume one pending detent (tuser 1),
// and each gives exactly one output beat with the consumed direction (0 none,
// 1 up, 2 down) and the signed pending detent count after the item. The block
// takes one beat per clock unless the output stalls; an item is held in the
// input register and its result in the result register, with a combinational
// state update between them, so back-pressure on the output only stalls the
// input once both registers are full. The last pin state starts at 00 after
// reset. Write detent_steps (index 0) and detent_state_mask (index 1) only
// while no items are in flight.
module quadrature_detent_decoder_unit #(
    parameter int PENDING_LIMIT = qdd_pkg::PENDING_LIMIT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // [0] pin_a, [1] pin_b
    input  logic                       s_axis_tuser,  // [0] kind
    // output stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,  // [1:0] direction, [9:2] pending_count
    // configuration writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [0:0]                 cfg_index,
    input  logic [qdd_pkg::CFG_W-1:0]  cfg_data
);
    import qdd_pkg::*;

    qdd_cfg_t    cfg;
    qdd_result_t result;

    // configuration registers
    qdd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // decoder datapath
    qdd_core #(
        .PENDING_LIMIT (PENDING_LIMIT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tuser),
        .in_pins    ({s_axis_tdata[0], s_axis_tdata[1]}),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // pack the result beat
    assign m_axis_tdata = {6'b0, result.pending_count, result.direction};

endmodule

[rtl/qdd_checker.sv]
`timescale 1ns / 1ps

module qdd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [15:0]                m_axis_tdata
);
    import qdd_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // direction code is never the unused value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("illegal direction code");

    // an up consume leaves a count that is not negative
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == DIR_UP |-> !m_axis_tdata[9])
        else $error("up consume left negative count");

    // a down consume leaves a count that is not positive
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == DIR_DOWN
            |-> m_axis_tdata[9] || m_axis_tdata[9:2] == 8'd0)
        else $error("down consume left positive count");

endmodule

bind quadrature_detent_decoder_unit qdd_checker u_qdd_checker (.*);
